// ===== src/hdbu_pkg.sv =====
// Shared types and constants for the dense HyperLogLog bucket update unit.
// No dependencies; used by the interfaces and the top level.
`default_nettype none
package hdbu_pkg;

  localparam int DEF_MAX_INDEX_BITS = 12;
  localparam int DEF_MAX_SPILLS     = 32;
  localparam int MIN_INDEX_BITS     = 4;
  localparam int RESET_INDEX_BITS   = 12;
  localparam int RANK_W             = 6;
  localparam int DELTA_W            = 4;
  localparam int CFG_W              = 4;
  localparam logic [DELTA_W-1:0] DELTA_MAX    = 4'd15;
  localparam logic [RANK_W-1:0]  BASELINE_MAX = 6'd63;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_MOD,
    S_SW_RD,
    S_SW_MOD,
    S_DONE
  } hdbu_state_t;

  // Size register clamped to [MIN_INDEX_BITS, max_bits]
  function automatic logic [4:0] clamp_bits(input logic [CFG_W-1:0] v, input int max_bits);
    logic [4:0] b;
    b = {1'b0, v};
    if (b < 5'(MIN_INDEX_BITS)) b = 5'(MIN_INDEX_BITS);
    if (b > 5'(max_bits)) b = 5'(max_bits);
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== src/hdbu_item_if.sv =====
// Input channel: valid/ready plus bucket index and rank.
// Depends on hdbu_pkg.
`default_nettype none
interface hdbu_item_if
  import hdbu_pkg::*;
#(
  parameter int AW = DEF_MAX_INDEX_BITS
);
  logic              valid;
  logic              ready;
  logic [AW-1:0]     bucket_index;
  logic [RANK_W-1:0] rank_value;
  modport source (output valid, bucket_index, rank_value, input ready);
  modport sink   (input valid, bucket_index, rank_value, output ready);
endinterface
`default_nettype wire

// ===== src/hdbu_result_if.sv =====
// Result channel: valid/ready plus the per-item status fields.
// Depends on hdbu_pkg.
`default_nettype none
interface hdbu_result_if
  import hdbu_pkg::*;
#(
  parameter int ZW  = DEF_MAX_INDEX_BITS + 1,
  parameter int SCW = $clog2(DEF_MAX_SPILLS + 1)
);
  logic              valid;
  logic              ready;
  logic              raised;
  logic [RANK_W-1:0] baseline_now;
  logic [ZW-1:0]     zero_delta_count;
  logic [SCW-1:0]    overflow_entries;
  logic              overflow_lost;
  logic              index_error;
  modport source (output valid, raised, baseline_now, zero_delta_count, overflow_entries,
                  overflow_lost, index_error, input ready);
  modport sink   (input valid, raised, baseline_now, zero_delta_count, overflow_entries,
                  overflow_lost, index_error, output ready);
endinterface
`default_nettype wire

// ===== src/hdbu_cfg_if.sv =====
// Configuration write channel: valid/ready plus the size register data.
// Depends on hdbu_pkg.
`default_nettype none
interface hdbu_cfg_if
  import hdbu_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/hll_dense_bucket_update_unit.sv =====
// Dense HyperLogLog bucket update unit: 4-bit deltas in a synchronous RAM, a small
// spill table in flops, and a rebase sweep. An ordinary item passes through accept,
// RAM read, modify/write and result; an out-of-range index goes from accept to result.
// Raising the last zero-delta bucket below the top baseline starts a rebase that
// visits every bucket in use, each with a RAM read then a write-back, per baseline
// step. After reset and after every write of index_bits a clearing pass writes
// 2^index_bits RAM entries, one per cycle, during which no item is taken. Items
// are taken singly; the rate is set by the single-port delta RAM read-modify-write.
// Depends on hdbu_pkg and the hdbu_*_if interfaces.
`default_nettype none
module hll_dense_bucket_update_unit
  import hdbu_pkg::*;
#(
  parameter int MAX_INDEX_BITS = DEF_MAX_INDEX_BITS,
  parameter int MAX_SPILLS     = DEF_MAX_SPILLS
) (
  input  wire           clk,
  input  wire           rst,
  hdbu_item_if.sink     item,
  hdbu_result_if.source result,
  hdbu_cfg_if.sink      cfg
);

  localparam int AW  = MAX_INDEX_BITS;
  localparam int ZW  = AW + 1;
  localparam int SCW = $clog2(MAX_SPILLS + 1);
  localparam int SIW = (MAX_SPILLS > 1) ? $clog2(MAX_SPILLS) : 1;

  hdbu_state_t state, state_next;

  logic [4:0]         index_bits;
  logic [AW-1:0]      addr;
  logic [RANK_W-1:0]  rank_q;
  logic [RANK_W-1:0]  baseline;
  logic [ZW-1:0]      zero_count;
  logic [SCW-1:0]     spill_count;
  logic [AW-1:0]      spill_bucket [MAX_SPILLS];
  logic [RANK_W-1:0]  spill_excess [MAX_SPILLS];
  logic               raised_q, lost_q, err_q;

  // delta RAM
  logic [DELTA_W-1:0] mem [2**AW];
  logic [DELTA_W-1:0] rdata;
  logic               mem_we;
  logic [DELTA_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    rdata <= mem[addr];
  end

  logic cfg_xfer, item_xfer, res_xfer, res_load;
  assign cfg.ready = 1'b1;
  assign cfg_xfer  = cfg.valid;
  assign item_xfer = item.valid && item.ready;
  assign res_xfer  = result.valid && result.ready;
  // result register takes a new transfer this cycle
  assign res_load  = (state == S_DONE) && !cfg_xfer && (!result.valid || result.ready);

  logic [AW-1:0] mask;
  assign mask = AW'((ZW'(1) << index_bits) - ZW'(1));
  logic idx_bad;
  assign idx_bad = ({1'b0, item.bucket_index} >> index_bits) != '0;

  // spill table lookup on the current bucket
  logic [MAX_SPILLS-1:0] match;
  logic                  hit;
  logic [SIW-1:0]        hit_i, last_i;
  logic [RANK_W-1:0]     hit_exc;
  always_comb begin
    hit_i = '0;
    for (int i = 0; i < MAX_SPILLS; i++) begin
      match[i] = (SCW'(i) < spill_count) && (spill_bucket[i] == addr);
      if (match[i]) hit_i = hit_i | SIW'(i);
    end
    hit     = |match;
    hit_exc = spill_excess[hit_i];
    last_i  = SIW'(spill_count - SCW'(1));
  end

  // insert evaluation
  logic [RANK_W:0]  dlt, cur;
  logic             raise, big;
  logic [RANK_W-1:0] exc;
  logic [ZW-1:0]    zc_dec;
  logic             go_rebase;
  always_comb begin
    dlt   = {1'b0, rank_q} - {1'b0, baseline};
    cur   = (RANK_W+1)'(rdata) +
            (((rdata == DELTA_MAX) && hit) ? (RANK_W+1)'(hit_exc) : '0);
    raise = !dlt[RANK_W] && (dlt > cur);
    big   = dlt > (RANK_W+1)'(DELTA_MAX);
    exc   = RANK_W'(dlt - (RANK_W+1)'(DELTA_MAX));
    zc_dec = ((rdata == '0) && (zero_count != '0)) ? zero_count - ZW'(1) : zero_count;
    go_rebase = raise && (rdata == '0) && (zc_dec == '0) && (baseline != BASELINE_MAX);
  end

  // sweep evaluation
  logic               spilled;
  logic [RANK_W-1:0]  exc_dec;
  logic [DELTA_W-1:0] new_d;
  logic [ZW-1:0]      zc_after;
  logic               sw_last, sw_again;
  always_comb begin
    spilled  = (rdata == DELTA_MAX) && hit;
    exc_dec  = hit_exc - RANK_W'(1);
    new_d    = (spilled || rdata == '0) ? rdata : rdata - DELTA_W'(1);
    zc_after = zero_count + ZW'(new_d == '0);
    sw_last  = addr == mask;
    sw_again = (zc_after == '0) && (baseline != BASELINE_MAX);
  end

  // next state
  always_comb begin
    state_next = state;
    if (cfg_xfer) begin
      state_next = S_CLR;
    end else begin
      unique case (state)
        S_CLR:    if (addr == mask) state_next = S_IDLE;
        S_IDLE:   if (item_xfer) state_next = idx_bad ? S_DONE : S_RD;
        S_RD:     state_next = S_MOD;
        S_MOD:    state_next = go_rebase ? S_SW_RD : S_DONE;
        S_SW_RD:  state_next = S_SW_MOD;
        S_SW_MOD: state_next = (sw_last && !sw_again) ? S_DONE : S_SW_RD;
        S_DONE:   if (!result.valid || result.ready) state_next = S_IDLE;
        default:  state_next = S_IDLE;
      endcase
    end
  end

  // outputs to RAM and input handshake
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state)
      S_CLR: mem_we = 1'b1;
      S_MOD: begin
        mem_we    = raise;
        mem_wdata = big ? DELTA_MAX : DELTA_W'(dlt);
      end
      S_SW_MOD: begin
        mem_we    = !spilled && (rdata != '0);
        mem_wdata = new_d;
      end
      default: mem_we = 1'b0;
    endcase
  end
  assign item.ready = (state == S_IDLE) && !cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      index_bits    <= clamp_bits(CFG_W'(RESET_INDEX_BITS), MAX_INDEX_BITS);
      addr          <= '0;
      baseline      <= '0;
      spill_count   <= '0;
      zero_count    <= ZW'(1) << clamp_bits(CFG_W'(RESET_INDEX_BITS), MAX_INDEX_BITS);
      result.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (res_xfer && !res_load) result.valid <= 1'b0;
      if (cfg_xfer) begin
        index_bits  <= clamp_bits(cfg.data, MAX_INDEX_BITS);
        addr        <= '0;
        baseline    <= '0;
        spill_count <= '0;
        zero_count  <= ZW'(1) << clamp_bits(cfg.data, MAX_INDEX_BITS);
      end else begin
        unique case (state)
          S_CLR: addr <= addr + AW'(1);
          S_IDLE: begin
            if (item_xfer) begin
              addr     <= item.bucket_index;
              rank_q   <= item.rank_value;
              err_q    <= idx_bad;
              raised_q <= 1'b0;
              lost_q   <= 1'b0;
            end
          end
          S_RD: ;
          S_MOD: begin
            raised_q <= raise;
            if (raise) begin
              if (big) begin
                if (hit) begin
                  spill_excess[hit_i] <= exc;
                end else if (spill_count < SCW'(MAX_SPILLS)) begin
                  spill_bucket[SIW'(spill_count)] <= addr;
                  spill_excess[SIW'(spill_count)] <= exc;
                  spill_count <= spill_count + SCW'(1);
                end else begin
                  lost_q <= 1'b1;
                end
              end
              zero_count <= zc_dec;
              if (go_rebase) begin
                baseline <= baseline + RANK_W'(1);
                addr     <= '0;
              end
            end
          end
          S_SW_RD: ;
          S_SW_MOD: begin
            if (spilled) begin
              if (exc_dec == '0) begin
                if (hit_i != last_i) begin
                  spill_bucket[hit_i] <= spill_bucket[last_i];
                  spill_excess[hit_i] <= spill_excess[last_i];
                end
                spill_count <= spill_count - SCW'(1);
              end else begin
                spill_excess[hit_i] <= exc_dec;
              end
            end
            zero_count <= zc_after;
            if (sw_last) begin
              addr <= '0;
              if (sw_again) baseline <= baseline + RANK_W'(1);
            end else begin
              addr <= addr + AW'(1);
            end
          end
          S_DONE: begin
            if (!result.valid || result.ready) begin
              result.valid            <= 1'b1;
              result.raised           <= raised_q;
              result.baseline_now     <= baseline;
              result.zero_delta_count <= zero_count;
              result.overflow_entries <= spill_count;
              result.overflow_lost    <= lost_q;
              result.index_error      <= err_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // checks
  a_spill_bound: assert property (@(posedge clk) disable iff (rst)
    spill_count <= SCW'(MAX_SPILLS)) else $error("spill count above table size");
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_xfer |=> (state == S_CLR) && (baseline == '0)) else $error("cfg did not clear");
  a_base_mono: assert property (@(posedge clk) disable iff (rst)
    !cfg_xfer |=> baseline >= $past(baseline)) else $error("baseline went down");
  a_item_busy: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> state != S_IDLE) else $error("item transfer without work");

endmodule
`default_nettype wire
